### src/cbm_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the cartridge bank mapper.
// Used by every module of the block but cbm_ram; depends on nothing.
package cbm_pkg;

    localparam int PATTERN_RAM_BYTES = 8192;
    localparam int PAT_ADDR_W        = $clog2(PATTERN_RAM_BYTES);
    localparam int BANK_W            = 8;
    localparam int NUM_WINDOWS       = 4;
    localparam int WINDOW_OFFSET_W   = 13;
    localparam int ROM_ADDR_W        = BANK_W + WINDOW_OFFSET_W;
    localparam int BANK_NUM_W        = 6;

    typedef enum logic [1:0] {
        CMD_PROG_WRITE = 2'd0,
        CMD_PROG_READ  = 2'd1,
        CMD_PAT_READ   = 2'd2,
        CMD_PAT_WRITE  = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        MODE_PAIRS     = 2'd0,
        MODE_UPPER     = 2'd1,
        MODE_ALL       = 2'd2,
        MODE_UPPER_ALT = 2'd3
    } wmode_t;

    // One classified access on its way from the front to the back.
    typedef struct packed {
        cmd_t                    kind;
        logic [PAT_ADDR_W-1:0]   ram_addr;
        logic [7:0]              wdata;
        logic [ROM_ADDR_W-1:0]   rom_addr;
        logic                    rom_valid;
        logic                    mirror;
    } q_entry_t;

endpackage

### src/cbm_ram.sv
`timescale 1ns / 1ps
// Generic simple dual-port RAM with registered read data.
// Stand-alone; no package needed.
module cbm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8192
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### src/cbm_front.sv
`timescale 1ns / 1ps
// Front end: accepts access transactions, keeps the window bank registers and
// the mirroring flag, and turns each access into a queue entry. Uses cbm_pkg.
module cbm_front (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [1:0]            s_command,
    input  logic [15:0]           s_address,
    input  logic [7:0]            s_write_byte,
    input  logic                  clearing,
    input  logic                  q_ready,
    output logic                  q_push,
    output cbm_pkg::q_entry_t     q_entry
);
    import cbm_pkg::*;

    logic [BANK_W-1:0]     banks_reg  [NUM_WINDOWS];
    logic [BANK_W-1:0]     banks_next [NUM_WINDOWS];
    logic                  mirror_reg;
    logic                  mirror_next;
    cmd_t                  cmd;
    wmode_t                mode;
    logic                  swap;
    logic [BANK_NUM_W-1:0] bank_num;
    logic [BANK_NUM_W:0]   bank_inc;
    logic [BANK_W-1:0]     lo_same;
    logic [BANK_W-1:0]     lo_flip;
    logic [BANK_W-1:0]     hi_same;
    logic [BANK_W-1:0]     hi_flip;
    logic [BANK_W-1:0]     sel_bank;
    logic                  accept;

    assign s_ready  = q_ready && !clearing;
    assign accept   = s_valid && s_ready;
    assign q_push   = accept;
    assign cmd      = cmd_t'(s_command);
    assign mode     = wmode_t'(s_address[1:0]);
    assign swap     = s_write_byte[7];
    assign bank_num = s_write_byte[BANK_NUM_W-1:0];
    assign bank_inc = {1'b0, bank_num} + {{BANK_NUM_W{1'b0}}, 1'b1};

    // Bank 2B+h for the selected pair and 2(B+1)+h for the following pair.
    assign lo_same = {1'b0, bank_num, swap};
    assign lo_flip = {1'b0, bank_num, ~swap};
    assign hi_same = {bank_inc, swap};
    assign hi_flip = {bank_inc, ~swap};

    always_comb begin
        for (int i = 0; i < NUM_WINDOWS; i++) begin
            banks_next[i] = banks_reg[i];
        end
        mirror_next = mirror_reg;
        if (accept && cmd == CMD_PROG_WRITE) begin
            mirror_next = s_write_byte[6];
            unique case (mode)
                MODE_PAIRS: begin
                    banks_next[0] = lo_same;
                    banks_next[1] = lo_flip;
                    banks_next[2] = hi_same;
                    banks_next[3] = hi_flip;
                end
                MODE_ALL: begin
                    for (int i = 0; i < NUM_WINDOWS; i++) begin
                        banks_next[i] = lo_same;
                    end
                end
                MODE_UPPER, MODE_UPPER_ALT: begin
                    banks_next[2] = lo_same;
                    banks_next[3] = lo_flip;
                end
                default: begin
                    banks_next[2] = lo_same;
                    banks_next[3] = lo_flip;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NUM_WINDOWS; i++) begin
                banks_reg[i] <= BANK_W'(i);
            end
            mirror_reg <= 1'b0;
        end else begin
            for (int i = 0; i < NUM_WINDOWS; i++) begin
                banks_reg[i] <= banks_next[i];
            end
            mirror_reg <= mirror_next;
        end
    end

    assign sel_bank = banks_reg[s_address[14:13]];

    always_comb begin
        q_entry.kind      = cmd;
        q_entry.ram_addr  = s_address[PAT_ADDR_W-1:0];
        q_entry.wdata     = s_write_byte;
        q_entry.rom_valid = (cmd == CMD_PROG_READ) && s_address[15];
        q_entry.rom_addr  = q_entry.rom_valid ?
                            {sel_bank, s_address[WINDOW_OFFSET_W-1:0]} : '0;
        // The flag reported is the one in force after this access.
        q_entry.mirror    = mirror_next;
    end

endmodule

### src/cbm_queue.sv
`timescale 1ns / 1ps
// Two-entry queue between the front end and the back end.
// Uses cbm_pkg for the entry type.
module cbm_queue (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  push,
    input  cbm_pkg::q_entry_t     push_entry,
    output logic                  push_ready,
    input  logic                  pop,
    output logic                  head_valid,
    output cbm_pkg::q_entry_t     head_entry
);
    import cbm_pkg::*;

    q_entry_t    slots_reg [2];
    logic        wr_ptr_reg;
    logic        rd_ptr_reg;
    logic [1:0]  count_reg;
    logic [1:0]  count_next;
    logic        do_push;
    logic        do_pop;

    assign push_ready = (count_reg != 2'd2);
    assign head_valid = (count_reg != 2'd0);
    assign head_entry = slots_reg[rd_ptr_reg];
    assign do_push    = push && push_ready;
    assign do_pop     = pop && head_valid;

    always_comb begin
        count_next = count_reg;
        if (do_push && !do_pop) begin
            count_next = count_reg + 2'd1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (do_pop) begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            slots_reg[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

### src/cbm_back.sv
`timescale 1ns / 1ps
// Back end: clears the pattern RAM after reset, carries out pattern reads and
// writes, and holds the result register. Uses cbm_pkg and cbm_ram.
module cbm_back (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 q_valid,
    input  cbm_pkg::q_entry_t                    q_entry,
    output logic                                 q_pop,
    output logic                                 clearing,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic [cbm_pkg::ROM_ADDR_W-1:0]       m_rom_byte_address,
    output logic                                 m_rom_address_valid,
    output logic [7:0]                           m_pattern_read_byte,
    output logic                                 m_mirror_horizontal
);
    import cbm_pkg::*;

    logic                  clr_active_reg;
    logic [PAT_ADDR_W-1:0] clr_addr_reg;
    logic                  fl_valid_reg;
    q_entry_t              fl_entry_reg;
    logic                  out_valid_reg;
    logic [ROM_ADDR_W-1:0] out_rom_reg;
    logic                  out_rom_valid_reg;
    logic [7:0]            out_pat_reg;
    logic                  out_mirror_reg;
    logic                  fl_move;
    logic                  ram_we;
    logic [PAT_ADDR_W-1:0] ram_waddr;
    logic [7:0]            ram_wdata;
    logic                  ram_re;
    logic [7:0]            ram_rdata;

    assign clearing = clr_active_reg;
    assign fl_move  = fl_valid_reg && (!out_valid_reg || m_ready);
    assign q_pop    = q_valid && !clr_active_reg && (!fl_valid_reg || fl_move);

    // The clearing pass owns the write port until every entry holds zero.
    assign ram_we    = clr_active_reg || (q_pop && q_entry.kind == CMD_PAT_WRITE);
    assign ram_waddr = clr_active_reg ? clr_addr_reg : q_entry.ram_addr;
    assign ram_wdata = clr_active_reg ? 8'd0 : q_entry.wdata;
    assign ram_re    = q_pop && q_entry.kind == CMD_PAT_READ;

    cbm_ram #(
        .WIDTH (8),
        .DEPTH (PATTERN_RAM_BYTES)
    ) u_pattern_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (q_entry.ram_addr),
        .rdata (ram_rdata)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_active_reg <= 1'b1;
            clr_addr_reg   <= '0;
            fl_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
        end else begin
            if (clr_active_reg) begin
                clr_addr_reg <= clr_addr_reg + PAT_ADDR_W'(1);
                if (clr_addr_reg == {PAT_ADDR_W{1'b1}}) begin
                    clr_active_reg <= 1'b0;
                end
            end
            if (q_pop) begin
                fl_valid_reg <= 1'b1;
            end else if (fl_move) begin
                fl_valid_reg <= 1'b0;
            end
            if (fl_move) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Read data stays on the RAM output while the in-flight entry waits,
    // because no new read is issued until it moves on.
    always_ff @(posedge aclk) begin
        if (q_pop) begin
            fl_entry_reg <= q_entry;
        end
        if (fl_move) begin
            out_rom_reg       <= fl_entry_reg.rom_addr;
            out_rom_valid_reg <= fl_entry_reg.rom_valid;
            out_pat_reg       <= (fl_entry_reg.kind == CMD_PAT_READ) ? ram_rdata : 8'd0;
            out_mirror_reg    <= fl_entry_reg.mirror;
        end
    end

    assign m_valid             = out_valid_reg;
    assign m_rom_byte_address  = out_rom_reg;
    assign m_rom_address_valid = out_rom_valid_reg;
    assign m_pattern_read_byte = out_pat_reg;
    assign m_mirror_horizontal = out_mirror_reg;

`ifndef SYNTH
    a_no_pop_while_clearing: assert property (@(posedge aclk) disable iff (!aresetn)
        clr_active_reg |-> !q_pop)
        else $error("queue popped during the RAM clearing pass");

    a_rdata_held: assert property (@(posedge aclk) disable iff (!aresetn)
        (fl_valid_reg && !fl_move) |=> $stable(ram_rdata))
        else $error("RAM read data changed under a stalled entry");

    a_rom_or_pattern: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_rom_address_valid) |-> (m_pattern_read_byte == 8'd0))
        else $error("program read result carries pattern data");

    a_invalid_rom_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_rom_address_valid) |-> (m_rom_byte_address == '0))
        else $error("nonzero ROM address without valid flag");
`endif

endmodule

### src/cartridge_bank_mapper_top.sv
`timescale 1ns / 1ps
// Cartridge bank mapper, top level: ties front end, queue and back end.
// Uses cbm_pkg, cbm_front, cbm_queue and cbm_back.
//
// Usage:
// The s_ channel carries one bus access per transaction: a command (program
// write, program read, pattern read, pattern write), a 16-bit address and a
// data byte. The m_ channel returns exactly one result per access, in order:
// the ROM byte address and its valid flag for program reads, the pattern RAM
// byte for pattern reads, and the mirroring flag in force after the access.
// Unused fields read as zero.
// Results pass through the queue, the in-flight and the result registers.
// Throughput: one access per cycle while m_ready is high and not clearing;
// bank lookups happen at acceptance; an item makes at most one RAM access.
// Reset: the bank registers return to 0, 1, 2, 3 and mirroring to vertical.
// The pattern RAM is then cleared, one byte per cycle, through all 8192
// bytes, and s_ready stays low throughout that pass.
// When the receiver stalls, the result register holds, the two-entry queue
// fills, and s_ready drops once the queue is full.
module cartridge_bank_mapper_top (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic [1:0]                     s_command,
    input  logic [15:0]                    s_address,
    input  logic [7:0]                     s_write_byte,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic [cbm_pkg::ROM_ADDR_W-1:0] m_rom_byte_address,
    output logic                           m_rom_address_valid,
    output logic [7:0]                     m_pattern_read_byte,
    output logic                           m_mirror_horizontal
);
    import cbm_pkg::*;

    q_entry_t push_entry;
    q_entry_t head_entry;
    logic     push;
    logic     push_ready;
    logic     head_valid;
    logic     pop;
    logic     clearing;

    cbm_front u_front (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_command    (s_command),
        .s_address    (s_address),
        .s_write_byte (s_write_byte),
        .clearing     (clearing),
        .q_ready      (push_ready),
        .q_push       (push),
        .q_entry      (push_entry)
    );

    cbm_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_entry (push_entry),
        .push_ready (push_ready),
        .pop        (pop),
        .head_valid (head_valid),
        .head_entry (head_entry)
    );

    cbm_back u_back (
        .aclk                (aclk),
        .aresetn             (aresetn),
        .q_valid             (head_valid),
        .q_entry             (head_entry),
        .q_pop               (pop),
        .clearing            (clearing),
        .m_valid             (m_valid),
        .m_ready             (m_ready),
        .m_rom_byte_address  (m_rom_byte_address),
        .m_rom_address_valid (m_rom_address_valid),
        .m_pattern_read_byte (m_pattern_read_byte),
        .m_mirror_horizontal (m_mirror_horizontal)
    );

endmodule

### tb/sv/tb_top.sv
`timescale 1ns / 1ps
// Self-checking testbench for cartridge_bank_mapper_top: a directed table, then random
// bus accesses, each result checked against an in-bench bank and pattern RAM predictor.
// Depends on cbm_pkg and the RTL of cartridge_bank_mapper_top only.
module tb_top;
    import cbm_pkg::*;

    localparam int ROM_ITEMS_RANDOM = 1650;
    localparam int WATCHDOG_LIMIT   = 50000;
    localparam int LONG_HOLD_CYCLES = 300;
    localparam int TAIL_CYCLES      = 10;
    localparam int DIR_ROWS         = 24;

    typedef struct packed {
        logic [ROM_ADDR_W-1:0] rom_addr;
        logic                  rom_valid;
        logic [7:0]            pat_byte;
        logic                  mirror;
    } map_result_t;

    typedef struct packed {
        cmd_t        cmd;
        logic [15:0] addr;
        logic [7:0]  data;
        logic        fix_en;
        map_result_t fix;
    } access_row_t;

    // Rows with fix_en set carry a result read straight off the reset state or an extreme.
    access_row_t dir_rows [DIR_ROWS] = '{
        '{CMD_PROG_READ,  16'h8000, 8'h00, 1'b1, '{21'h000000, 1'b1, 8'h00, 1'b0}},
        '{CMD_PROG_READ,  16'hFFFF, 8'h00, 1'b1, '{21'h007FFF, 1'b1, 8'h00, 1'b0}},
        '{CMD_PROG_READ,  16'h7FFF, 8'hFF, 1'b1, '{21'h000000, 1'b0, 8'h00, 1'b0}},
        '{CMD_PROG_READ,  16'h0000, 8'h00, 1'b1, '{21'h000000, 1'b0, 8'h00, 1'b0}},
        '{CMD_PAT_READ,   16'h0000, 8'h00, 1'b1, '{21'h000000, 1'b0, 8'h00, 1'b0}},
        '{CMD_PAT_READ,   16'hFFFF, 8'h00, 1'b1, '{21'h000000, 1'b0, 8'h00, 1'b0}},
        '{CMD_PAT_WRITE,  16'h1FFF, 8'hFF, 1'b1, '{21'h000000, 1'b0, 8'h00, 1'b0}},
        '{CMD_PAT_READ,   16'hFFFF, 8'h00, 1'b1, '{21'h000000, 1'b0, 8'hFF, 1'b0}},
        '{CMD_PAT_WRITE,  16'hE000, 8'hA5, 1'b0, '0},
        '{CMD_PAT_READ,   16'h0000, 8'h00, 1'b0, '0},
        '{CMD_PROG_WRITE, 16'h8000, 8'hFF, 1'b1, '{21'h000000, 1'b0, 8'h00, 1'b1}},
        '{CMD_PROG_READ,  16'h8000, 8'h00, 1'b0, '0},
        '{CMD_PROG_READ,  16'hE000, 8'h00, 1'b0, '0},
        '{CMD_PROG_WRITE, 16'hFFFC, 8'h3F, 1'b0, '0},
        '{CMD_PROG_READ,  16'hFFFF, 8'h00, 1'b1, '{21'h103FFF, 1'b1, 8'h00, 1'b0}},
        '{CMD_PROG_WRITE, 16'h8001, 8'hC5, 1'b0, '0},
        '{CMD_PROG_READ,  16'hC000, 8'h00, 1'b0, '0},
        '{CMD_PROG_READ,  16'hA123, 8'h00, 1'b0, '0},
        '{CMD_PROG_WRITE, 16'h8003, 8'h00, 1'b0, '0},
        '{CMD_PROG_READ,  16'hDFFF, 8'h00, 1'b0, '0},
        '{CMD_PROG_WRITE, 16'h8002, 8'hBF, 1'b0, '0},
        '{CMD_PROG_READ,  16'h9000, 8'h00, 1'b0, '0},
        '{CMD_PROG_READ,  16'hF000, 8'h00, 1'b0, '0},
        '{CMD_PAT_READ,   16'h1FFF, 8'h00, 1'b0, '0}
    };

    logic                  aclk          = 1'b0;
    logic                  aresetn       = 1'b0;
    logic                  s_valid       = 1'b0;
    logic                  s_ready;
    logic [1:0]            s_command     = 2'd0;
    logic [15:0]           s_address     = 16'd0;
    logic [7:0]            s_write_byte  = 8'd0;
    logic                  m_valid;
    logic                  m_ready       = 1'b0;
    logic [ROM_ADDR_W-1:0] m_rom_byte_address;
    logic                  m_rom_address_valid;
    logic [7:0]            m_pattern_read_byte;
    logic                  m_mirror_horizontal;

    // Known result riding along with the transaction currently offered, if any.
    logic                  drv_fix_en    = 1'b0;
    map_result_t           drv_fix       = '0;

    logic [BANK_W-1:0]     bank_regs [NUM_WINDOWS];
    logic                  mirror_state;
    logic [7:0]            pattern_mem [PATTERN_RAM_BYTES];
    map_result_t           pending_results [$];

    int                    mismatches    = 0;
    int                    quiet_cycles  = 0;
    int                    idle_pct      = 0;
    int                    stall_left    = 0;
    bit                    hold_req      = 1'b0;

    cartridge_bank_mapper_top uut (
        .aclk                (aclk),
        .aresetn             (aresetn),
        .s_valid             (s_valid),
        .s_ready             (s_ready),
        .s_command           (s_command),
        .s_address           (s_address),
        .s_write_byte        (s_write_byte),
        .m_valid             (m_valid),
        .m_ready             (m_ready),
        .m_rom_byte_address  (m_rom_byte_address),
        .m_rom_address_valid (m_rom_address_valid),
        .m_pattern_read_byte (m_pattern_read_byte),
        .m_mirror_horizontal (m_mirror_horizontal)
    );

    initial begin
        forever begin
            #5 aclk = ~aclk;
        end
    end

    function automatic logic [BANK_W-1:0] pair_bank(logic [6:0] bank, logic half);
        return BANK_W'({bank, 1'b0} + half);
    endfunction

    // Applies one access to the predicted mapper state and returns its result.
    task automatic map_access(input cmd_t cmd, input logic [15:0] addr,
                              input logic [7:0] data, output map_result_t res);
        logic [6:0] bank_num;
        logic       swap;
        bank_num = {1'b0, data[5:0]};
        swap     = data[7];
        res      = '0;
        case (cmd)
            CMD_PROG_WRITE: begin
                case (wmode_t'(addr[1:0]))
                    MODE_PAIRS: begin
                        bank_regs[0] = pair_bank(bank_num, swap);
                        bank_regs[1] = pair_bank(bank_num, ~swap);
                        bank_regs[2] = pair_bank(bank_num + 7'd1, swap);
                        bank_regs[3] = pair_bank(bank_num + 7'd1, ~swap);
                    end
                    MODE_ALL: begin
                        for (int w = 0; w < NUM_WINDOWS; w++) begin
                            bank_regs[w] = pair_bank(bank_num, swap);
                        end
                    end
                    default: begin
                        bank_regs[2] = pair_bank(bank_num, swap);
                        bank_regs[3] = pair_bank(bank_num, ~swap);
                    end
                endcase
                mirror_state = data[6];
            end
            CMD_PROG_READ: begin
                if (addr[15]) begin
                    res.rom_addr  = {bank_regs[addr[14:13]], addr[12:0]};
                    res.rom_valid = 1'b1;
                end
            end
            CMD_PAT_READ: begin
                res.pat_byte = pattern_mem[addr[12:0]];
            end
            default: begin
                pattern_mem[addr[12:0]] = data;
            end
        endcase
        res.mirror = mirror_state;
    endtask

    function automatic int pick_gap();
        if ($urandom_range(0, 99) < 85) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    // Entered and left at a falling edge; valid stays high across back-to-back items.
    task automatic send_access(input cmd_t cmd, input logic [15:0] addr,
                               input logic [7:0] data, input logic fix_en,
                               input map_result_t fix);
        int gap;
        gap = ($urandom_range(0, 99) < idle_pct) ? pick_gap() : 0;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid      <= 1'b1;
        s_command    <= cmd;
        s_address    <= addr;
        s_write_byte <= data;
        drv_fix_en   <= fix_en;
        drv_fix      <= fix;
        do begin
            @(posedge aclk);
        end while (!s_ready);
        @(negedge aclk);
    endtask

    task automatic send_random(input int count);
        cmd_t        cmd;
        logic [15:0] addr;
        logic [7:0]  data;
        for (int n = 0; n < count; n++) begin
            cmd  = cmd_t'($urandom_range(0, 3));
            addr = 16'($urandom);
            data = 8'($urandom);
            if (cmd == CMD_PROG_READ && $urandom_range(0, 9) < 8) begin
                addr[15] = 1'b1;
            end
            // Keep pattern traffic in a small corner now and then so reads hit written bytes.
            if ((cmd == CMD_PAT_READ || cmd == CMD_PAT_WRITE) && $urandom_range(0, 1) == 1) begin
                addr[12:0] = 13'($urandom_range(0, 31));
            end
            send_access(cmd, addr, data, 1'b0, '0);
        end
    endtask

    task automatic drain_results();
        s_valid <= 1'b0;
        do begin
            @(negedge aclk);
        end while (pending_results.size() != 0);
    endtask

    initial begin
        bank_regs[0] = 8'd0;
        bank_regs[1] = 8'd1;
        bank_regs[2] = 8'd2;
        bank_regs[3] = 8'd3;
        mirror_state = 1'b0;
        for (int a = 0; a < PATTERN_RAM_BYTES; a++) begin
            pattern_mem[a] = 8'd0;
        end
        repeat (4) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        for (int r = 0; r < DIR_ROWS; r++) begin
            send_access(dir_rows[r].cmd, dir_rows[r].addr, dir_rows[r].data,
                        dir_rows[r].fix_en, dir_rows[r].fix);
        end

        idle_pct = 0;
        send_random(200);
        idle_pct = 30;
        send_random(600);

        // The receiver stalls while the sender keeps pushing, so the queue backs up.
        idle_pct = 0;
        hold_req = 1'b1;
        send_random(100);
        drain_results();

        idle_pct = 45;
        send_random(ROM_ITEMS_RANDOM - 900);
        drain_results();

        repeat (TAIL_CYCLES) @(negedge aclk);
        if (mismatches == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    initial begin
        @(posedge aresetn);
        forever begin
            @(negedge aclk);
            if (hold_req) begin
                m_ready <= 1'b0;
                repeat (LONG_HOLD_CYCLES) @(negedge aclk);
                hold_req = 1'b0;
            end else if (stall_left > 0) begin
                m_ready <= 1'b0;
                stall_left--;
            end else if ($urandom_range(0, 99) < idle_pct) begin
                m_ready <= 1'b0;
                stall_left = pick_gap() - 1;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    always @(posedge aclk) begin
        map_result_t want;
        map_result_t got;
        if (aresetn) begin
            if (s_valid && s_ready) begin
                map_access(cmd_t'(s_command), s_address, s_write_byte, want);
                if (drv_fix_en) begin
                    want = drv_fix;
                end
                pending_results.push_back(want);
            end
            if (m_valid && m_ready) begin
                got = '{m_rom_byte_address, m_rom_address_valid,
                        m_pattern_read_byte, m_mirror_horizontal};
                if (pending_results.size() == 0) begin
                    mismatches++;
                    $display("%0t: unexpected result rom=%h valid=%b pat=%h mirror=%b",
                             $time, got.rom_addr, got.rom_valid, got.pat_byte, got.mirror);
                end else begin
                    want = pending_results.pop_front();
                    if (got.rom_addr !== want.rom_addr || got.rom_valid !== want.rom_valid ||
                        got.pat_byte !== want.pat_byte || got.mirror !== want.mirror) begin
                        mismatches++;
                        $display("%0t: expected rom=%h valid=%b pat=%h mirror=%b",
                                 $time, want.rom_addr, want.rom_valid, want.pat_byte,
                                 want.mirror);
                        $display("%0t: actual   rom=%h valid=%b pat=%h mirror=%b",
                                 $time, got.rom_addr, got.rom_valid, got.pat_byte,
                                 got.mirror);
                    end
                end
            end
        end
    end

    // The clearing pass after reset keeps s_ready low; the limit covers that pass.
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

endmodule
